>>> src/dvr_pkg.sv
// Package for the distance-vector route update block.
// Holds sizes, cost constants, codes, shared structs and the saturating cost helper.
// No dependencies.
package dvr_pkg;

	localparam int NODES  = 8;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;
	localparam int COST_W = 7;
	localparam int ADDR_W = 2 * IDX_W;

	localparam logic [COST_W-1:0] INF_COST = 7'd99;

	// Input command codes.
	typedef enum logic [1:0] {
		MODE_SET_LINK  = 2'd0,
		MODE_DISABLE   = 2'd1,
		MODE_STORE     = 2'd2,
		MODE_RECOMPUTE = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_NODE_ID    = 2'd0;
	localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
	localparam logic [1:0] CFG_NEIGH_MASK = 2'd2;

	// Engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEST,
		ST_SWEEP,
		ST_WAIT,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] node_id;
		logic [CNT_W-1:0] node_count;
		logic [NODES-1:0] neighbor_mask;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0]  dest;
		logic [COST_W-1:0] cost;
		logic [IDX_W-1:0]  via;
		logic              entry_changed;
		logic              vector_changed;
		logic              last;
		logic              status;
	} result_t;

	// Clamp a cost sum at the infinite cost.
	function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] v);
		if (v >= {1'b0, INF_COST}) begin
			return INF_COST;
		end
		return v[COST_W-1:0];
	endfunction

endpackage

>>> src/distance_vector_route_update_top.sv
// Distance-vector route update block, top level.
// Input and result channels use valid/stall; every transfer happens at a rising
// edge with valid high and stall low. Configuration uses a plain write port.
//
// Set link, disable link and store entry commands each produce one
// acknowledgement result, ready in the cycle after the input transfer; status
// flags a disable of a node that is not a live neighbor.
// A recompute produces one result per destination other than this node, the
// final one marked last and carrying the vector change flag. Each destination
// passes through a set-up step, eight reads of the single cost table read port
// (one per table row), a step for the last read to return and a step that
// writes back and loads the result; the sequencer handles one command at a time.
// Results sit in an output register. A stalled result holds, and the engine
// waits in its final step until the register frees up. New input is taken
// only when the engine is idle and the output register can accept a result.
// Reset clears all state at once: link costs and the cost table go to
// infinity with zero at node 0, every neighbor is alive and the first
// recompute reports a vector change. No clearing pass is needed.
// Depends on dvr_pkg and dvr_engine.
module distance_vector_route_update_top
	import dvr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [NODES-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [IDX_W-1:0]  peer,
	input  logic [IDX_W-1:0]  dest,
	input  logic [COST_W-1:0] cost,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [IDX_W-1:0]  route_dest,
	output logic [COST_W-1:0] route_cost,
	output logic [IDX_W-1:0]  route_via,
	output logic              entry_changed,
	output logic              vector_changed,
	output logic              last,
	output logic              status
);

	cfg_t    cfg_q;
	result_t out_q;
	logic    out_valid_q;
	logic    out_free;
	logic    res_load;
	result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id       <= '0;
			cfg_q.node_count    <= CNT_W'(NODES);
			cfg_q.neighbor_mask <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_ID:    cfg_q.node_id       <= cfg_data[IDX_W-1:0];
				CFG_NODE_COUNT: cfg_q.node_count    <= cfg_data[CNT_W-1:0];
				CFG_NEIGH_MASK: cfg_q.neighbor_mask <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dvr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.peer     (peer),
		.dest     (dest),
		.cost     (cost),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res)
	);

	// Output register: free when empty or when its result transfers this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign route_dest     = out_q.dest;
	assign route_cost     = out_q.cost;
	assign route_via      = out_q.via;
	assign entry_changed  = out_q.entry_changed;
	assign vector_changed = out_q.vector_changed;
	assign last           = out_q.last;
	assign status         = out_q.status;

endmodule

>>> src/dvr_cost_mem.sv
// Cost table memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as their reset cost.
// Depends on dvr_pkg.
module dvr_cost_mem
	import dvr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [COST_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [COST_W-1:0] rd_data
);

	localparam int DEPTH = NODES * NODES;

	logic [COST_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [COST_W-1:0] data_s1;
	logic              vld_s1;
	logic              zero_s1;

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			zero_s1 <= (rd_addr == '0);
		end
	end

	// Valid bits clear at reset; the read side samples them with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	// The entry of the reset-time own node reads zero, every other one infinity.
	assign rd_data = vld_s1 ? data_s1 : (zero_s1 ? '0 : INF_COST);

endmodule

>>> src/dvr_engine.sv
// Route update engine: command decode, link state and the recompute sequencer.
// Reads the cost table column by column, keeps the running minimum and writes back.
// Depends on dvr_pkg and dvr_cost_mem.
module dvr_engine
	import dvr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [IDX_W-1:0]  peer,
	input  logic [IDX_W-1:0]  dest,
	input  logic [COST_W-1:0] cost,
	input  logic              out_free,
	output logic              res_load,
	output result_t           res
);

	state_t state_q, state_d;

	logic [COST_W-1:0] link_cost_q [NODES];
	logic [IDX_W-1:0]  next_hop_q [NODES];
	logic [NODES-1:0]  alive_q;
	logic              dirty_q;

	logic [IDX_W-1:0]  jn_q;
	logic [IDX_W-1:0]  r_q;
	logic [COST_W-1:0] best_q;
	logic [IDX_W-1:0]  via_q;
	logic              found_q;
	logic [COST_W-1:0] old_q;
	logic              any_q;

	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_r_s1;

	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [COST_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [COST_W-1:0] mem_rd_data;

	logic              accept;
	mode_t             cmd;
	logic [COST_W-1:0] cost_sat;
	logic              disable_ok;
	logic [IDX_W-1:0]  self;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  last_j;
	logic              has_dest;
	logic              is_last;
	logic              changed;
	logic              upd;
	logic [COST_W:0]   cand_sum;
	logic [COST_W-1:0] cand;

	dvr_cost_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr ({r_q, jn_q}),
		.rd_data (mem_rd_data)
	);

	// Command decode and recompute bounds.
	assign in_stall   = !((state_q == ST_IDLE) && out_free);
	assign accept     = in_valid && !in_stall;
	assign cmd        = mode_t'(mode);
	assign cost_sat   = sat_cost({1'b0, cost});
	assign disable_ok = alive_q[peer] && cfg.neighbor_mask[peer];
	assign self       = cfg.node_id;
	assign cnt        = (cfg.node_count > CNT_W'(NODES)) ? CNT_W'(NODES) : cfg.node_count;
	assign last_j     = ((cnt - 1'b1) != {1'b0, self}) ? cnt - 1'b1 : cnt - CNT_W'(2);
	assign has_dest   = (cnt >= CNT_W'(2)) || ((cnt == CNT_W'(1)) && (self != '0));
	assign is_last    = ({1'b0, jn_q} == last_j);
	assign changed    = (old_q != best_q);
	assign upd        = changed || dirty_q;

	// Candidate cost of the row that returns from the memory this cycle.
	assign cand_sum = {1'b0, link_cost_q[rd_r_s1]} + {1'b0, mem_rd_data};
	assign cand     = sat_cost(cand_sum);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory access and result loading. Reads happen only in the
	// sweep and writes only in idle or final, so an entry is never read and
	// written in the same cycle.
	always_comb begin
		state_d     = state_q;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = {peer, dest};
		mem_wr_data = cost_sat;
		res_load    = 1'b0;
		res         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == MODE_RECOMPUTE) begin
						if (has_dest) begin
							state_d = ST_DEST;
						end
					end else begin
						res_load   = 1'b1;
						res.last   = 1'b1;
						res.status = (cmd == MODE_DISABLE) && !disable_ok;
						mem_wr_en  = (cmd == MODE_STORE);
					end
				end
			end
			ST_DEST: begin
				if (jn_q != self) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				mem_rd_en = 1'b1;
				if (r_q == IDX_W'(NODES - 1)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				if (out_free) begin
					res_load           = 1'b1;
					res.dest           = jn_q;
					res.cost           = best_q;
					res.via            = upd ? via_q : next_hop_q[jn_q];
					res.entry_changed  = changed;
					res.vector_changed = is_last && (any_q || changed || dirty_q);
					res.last           = is_last;
					mem_wr_en          = upd;
					mem_wr_addr        = {self, jn_q};
					mem_wr_data        = best_q;
					state_d            = is_last ? ST_IDLE : ST_DEST;
				end
			end
		endcase
	end

	// Link costs, next hops, neighbor liveness and the link change flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				link_cost_q[i] <= (i == 0) ? '0 : INF_COST;
				next_hop_q[i]  <= '0;
			end
			alive_q   <= '1;
			dirty_q   <= 1'b1;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_rd_en;
			if (state_q == ST_IDLE && accept) begin
				if (cmd == MODE_SET_LINK) begin
					link_cost_q[peer] <= cost_sat;
					dirty_q           <= 1'b1;
				end else if (cmd == MODE_DISABLE && disable_ok) begin
					link_cost_q[peer] <= INF_COST;
					alive_q[peer]     <= 1'b0;
					dirty_q           <= 1'b1;
				end
			end
			if (state_q == ST_FINAL && out_free) begin
				if (upd) begin
					next_hop_q[jn_q] <= via_q;
				end
				if (is_last) begin
					dirty_q <= 1'b0;
				end
			end
		end
	end

	// Walk counters and the running minimum over candidate next hops.
	always_ff @(posedge clk) begin
		rd_r_s1 <= r_q;
		unique case (state_q)
			ST_IDLE: begin
				jn_q  <= '0;
				any_q <= 1'b0;
			end
			ST_DEST: begin
				if (jn_q == self) begin
					jn_q <= jn_q + 1'b1;
				end else begin
					r_q     <= '0;
					best_q  <= INF_COST;
					via_q   <= '0;
					found_q <= 1'b0;
				end
			end
			ST_SWEEP: begin
				r_q <= r_q + 1'b1;
			end
			ST_WAIT: begin
			end
			ST_FINAL: begin
				if (out_free) begin
					any_q <= any_q || changed;
					jn_q  <= jn_q + 1'b1;
				end
			end
		endcase
		// The own row gives the previous best cost; other rows in use are candidates.
		if (rd_vld_s1) begin
			if (rd_r_s1 == self) begin
				old_q <= mem_rd_data;
			end else if (({1'b0, rd_r_s1} < cnt) && (!found_q || cand < best_q)) begin
				best_q  <= cand;
				via_q   <= rd_r_s1;
				found_q <= 1'b1;
			end
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr_en && mem_rd_en))
		else $error("cost table read and write in the same cycle");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded while the output register is occupied");

	a_last_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.last) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after the last result");

	a_read_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SWEEP))
		else $error("read data returned without a sweep read");

endmodule
